// ----- rtl/pcs_pkg.sv -----
// Shared constants, codes and control structs for the packed Cholesky solver.
`default_nettype none

package pcs_pkg;

  localparam int MAX_ORDER_DEF = 16;
  localparam int FRAC_BITS_DEF = 16;

  localparam int DATA_W = 32;
  localparam int ACC_W  = 64;
  localparam int SIZE_W = 5;
  localparam int IDX_W  = 4;
  localparam int STAT_W = 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  // Input item kinds.
  localparam logic KIND_MATRIX = 1'b0;
  localparam logic KIND_RHS    = 1'b1;

  // Result item kinds.
  localparam logic RES_STATUS   = 1'b0;
  localparam logic RES_SOLUTION = 1'b1;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_PD    = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_FACTOR = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              f_we;
    logic              f_wsel_unit;
    logic              v_we;
    logic              v_wsel_unit;
    logic              acc_load;
    logic              acc_src_vec;
    logic              mul_en;
    logic              mul_b_vec;
    logic              acc_sub;
    logic              sum_latch;
    logic              sqrt_start;
    logic              div_start;
    logic              emit;
    logic              emit_kind;
    logic [STAT_W-1:0] emit_status;
    logic              emit_last;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic unit_done;
    logic sum_pos;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/pcs_if.sv -----
// Valid/ready channel interfaces for the solver input and result streams.
`default_nettype none

interface pcs_in_if import pcs_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface pcs_out_if import pcs_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic                     result_kind;
  logic [STAT_W-1:0]        status;
  logic [IDX_W-1:0]         index;
  logic signed [DATA_W-1:0] solved_value;
  logic                     last;

  modport source (output valid, output result_kind, output status, output index,
                  output solved_value, output last, input ready);
  modport sink   (input valid, input result_kind, input status, input index,
                  input solved_value, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/pcs_divsqrt.sv -----
// Iterative unit: one quotient bit or one root bit per cycle, saturated result.
`default_nettype none

module pcs_divsqrt import pcs_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start_div,
  input  logic                     start_sqrt,
  input  logic signed [DATA_W-1:0] num,
  input  logic signed [DATA_W-1:0] den,
  output logic                     done,
  output logic signed [DATA_W-1:0] result
);

  localparam int NW    = DATA_W + FRAC_BITS;
  localparam int RW    = 2 * DATA_W;
  localparam int CNT_W = $clog2(NW + 1);

  localparam logic [NW-1:0] POS_LIM = NW'({1'b0, {(DATA_W-1){1'b1}}});
  localparam logic [NW-1:0] NEG_LIM = NW'({1'b1, {(DATA_W-1){1'b0}}});

  logic              busy;
  logic              is_sqrt;
  logic              den_zero;
  logic              neg;
  logic              num_neg;
  logic [CNT_W-1:0]  cnt;
  logic [NW-1:0]     dq;
  logic [DATA_W-1:0] dmod;
  logic [DATA_W-1:0] drem;
  logic [RW-1:0]     rad;
  logic [DATA_W-1:0] root;
  logic [DATA_W+1:0] srem;

  logic [DATA_W-1:0] num_mag;
  logic [DATA_W-1:0] den_mag;
  logic [DATA_W:0]   d_sh;
  logic              d_ge;
  logic [DATA_W+3:0] s_sh;
  logic [DATA_W+3:0] s_trial;
  logic              s_ge;

  assign num_mag = num[DATA_W-1] ? (~num + 1'b1) : num;
  assign den_mag = den[DATA_W-1] ? (~den + 1'b1) : den;

  assign d_sh    = {drem, dq[NW-1]};
  assign d_ge    = d_sh >= {1'b0, dmod};
  assign s_sh    = {srem, rad[RW-1:RW-2]};
  assign s_trial = {2'b00, root, 2'b01};
  assign s_ge    = s_sh >= s_trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start_div) begin
        is_sqrt  <= 1'b0;
        den_zero <= (den == '0);
        neg      <= num[DATA_W-1] ^ den[DATA_W-1];
        num_neg  <= num[DATA_W-1];
        dq       <= {num_mag, {FRAC_BITS{1'b0}}};
        dmod     <= den_mag;
        drem     <= '0;
        cnt      <= CNT_W'(NW);
        busy     <= (den != '0);
        done     <= (den == '0);
      end else if (start_sqrt) begin
        is_sqrt  <= 1'b1;
        den_zero <= 1'b0;
        rad      <= RW'({num, {FRAC_BITS{1'b0}}});
        root     <= '0;
        srem     <= '0;
        cnt      <= CNT_W'(DATA_W);
        busy     <= 1'b1;
      end else if (busy) begin
        if (is_sqrt) begin
          srem <= (DATA_W+2)'(s_ge ? (s_sh - s_trial) : s_sh);
          root <= {root[DATA_W-2:0], s_ge};
          rad  <= rad << 2;
        end else begin
          drem <= DATA_W'(d_ge ? (d_sh - {1'b0, dmod}) : d_sh);
          dq   <= {dq[NW-2:0], d_ge};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (is_sqrt) begin
      result = root;
    end else if (den_zero) begin
      result = num_neg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else if (neg) begin
      result = (dq > NEG_LIM) ? {1'b1, {(DATA_W-1){1'b0}}} : (~dq[DATA_W-1:0] + 1'b1);
    end else begin
      result = (dq > POS_LIM) ? {1'b0, {(DATA_W-1){1'b1}}} : dq[DATA_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pcs_datapath.sv -----
// Datapath: factor and vector memories, multiply-accumulate, div/sqrt unit, result register.
`default_nettype none

module pcs_datapath import pcs_pkg::*; #(
  parameter int MAX_ORDER = MAX_ORDER_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  dp_cmd_t                        cmd,
  output dp_stat_t                       stat,
  input  logic [$clog2(MAX_ORDER*(MAX_ORDER+1)/2)-1:0] f_ra,
  input  logic [$clog2(MAX_ORDER*(MAX_ORDER+1)/2)-1:0] f_rb,
  input  logic [$clog2(MAX_ORDER*(MAX_ORDER+1)/2)-1:0] f_wa,
  input  logic [$clog2(MAX_ORDER)-1:0]   v_ra,
  input  logic [$clog2(MAX_ORDER)-1:0]   v_wa,
  input  logic [IDX_W-1:0]               emit_index,
  input  logic signed [DATA_W-1:0]       in_value,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic                           out_result_kind,
  output logic [STAT_W-1:0]              out_status,
  output logic [IDX_W-1:0]               out_index,
  output logic signed [DATA_W-1:0]       out_value,
  output logic                           out_last
);

  localparam int TRI = MAX_ORDER * (MAX_ORDER + 1) / 2;

  localparam logic signed [ACC_W-1:0] HALF = {{(ACC_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO =
    {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

  logic signed [DATA_W-1:0] fmem [TRI];
  logic signed [DATA_W-1:0] vmem [MAX_ORDER];
  logic signed [DATA_W-1:0] fa_q;
  logic signed [DATA_W-1:0] fb_q;
  logic signed [DATA_W-1:0] vq;
  logic signed [ACC_W-1:0]  prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [DATA_W-1:0] sum;

  logic signed [DATA_W-1:0] mul_b;
  logic signed [DATA_W-1:0] acc_src;
  logic signed [ACC_W-1:0]  prod_rnd;
  logic signed [DATA_W-1:0] unit_result;
  logic                     unit_done;
  logic signed [DATA_W-1:0] wdata;

  assign mul_b    = cmd.mul_b_vec ? vq : fb_q;
  assign acc_src  = cmd.acc_src_vec ? vq : fa_q;
  assign prod_rnd = (prod + HALF) >>> FRAC_BITS;

  pcs_divsqrt #(.FRAC_BITS(FRAC_BITS)) u_divsqrt (
    .clk        (clk),
    .rst        (rst),
    .start_div  (cmd.div_start),
    .start_sqrt (cmd.sqrt_start),
    .num        (sum),
    .den        (fb_q),
    .done       (unit_done),
    .result     (unit_result)
  );

  // Factor store: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (cmd.f_we) begin
      fmem[f_wa] <= cmd.f_wsel_unit ? unit_result : in_value;
    end
    fa_q <= fmem[f_ra];
    fb_q <= fmem[f_rb];
  end

  assign wdata = cmd.v_wsel_unit ? unit_result : in_value;

  // Vector store: right-hand side, overwritten in place by the solution.
  always_ff @(posedge clk) begin
    if (cmd.v_we) begin
      vmem[v_wa] <= wdata;
    end
    vq <= vmem[v_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= fa_q * mul_b;
    end
    if (cmd.acc_load) begin
      acc <= ACC_W'(acc_src);
    end else if (cmd.acc_sub) begin
      acc <= acc - prod_rnd;
    end
    if (cmd.sum_latch) begin
      if (acc > SAT_HI) begin
        sum <= SAT_HI[DATA_W-1:0];
      end else if (acc < SAT_LO) begin
        sum <= SAT_LO[DATA_W-1:0];
      end else begin
        sum <= acc[DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_result_kind <= cmd.emit_kind;
      out_status      <= cmd.emit_status;
      out_index       <= (cmd.emit_kind == RES_SOLUTION) ? emit_index : '0;
      out_value       <= (cmd.emit_kind == RES_SOLUTION) ? vq : '0;
      out_last        <= cmd.emit_last;
    end
  end

  assign stat.unit_done = unit_done;
  assign stat.sum_pos   = (sum > 0);
  assign stat.out_free  = !out_valid || out_ready;

endmodule

`default_nettype wire

// ----- rtl/pcs_ctrl.sv -----
// Controller: load counters, order register and the factor/solve sequencer.
`default_nettype none

module pcs_ctrl import pcs_pkg::*; #(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [SIZE_W-1:0]              cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_kind,
  output logic                           in_ready,
  input  dp_stat_t                       stat,
  output dp_cmd_t                        cmd,
  output logic [$clog2(MAX_ORDER*(MAX_ORDER+1)/2)-1:0] f_ra,
  output logic [$clog2(MAX_ORDER*(MAX_ORDER+1)/2)-1:0] f_rb,
  output logic [$clog2(MAX_ORDER*(MAX_ORDER+1)/2)-1:0] f_wa,
  output logic [$clog2(MAX_ORDER)-1:0]   v_ra,
  output logic [$clog2(MAX_ORDER)-1:0]   v_wa,
  output logic [IDX_W-1:0]               emit_index
);

  localparam int TRI = MAX_ORDER * (MAX_ORDER + 1) / 2;
  localparam int AW  = $clog2(TRI);
  localparam int MW  = $clog2(TRI + 1);
  localparam int IW  = $clog2(MAX_ORDER);
  localparam int CW  = $clog2(MAX_ORDER + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_BASE, S_LOAD, S_RD, S_MUL, S_ACC, S_SUM, S_OP, S_WAIT,
    S_E_RD, S_E_OUT, S_STAT
  } state_t;

  typedef enum logic [1:0] {M_FACT, M_FWD, M_BWD} mode_t;

  state_t            state;
  mode_t             mode;
  logic [SIZE_W-1:0] cfg_size;
  logic [AW-1:0]     mcount;
  logic [IW-1:0]     vcount;
  logic              fgood;
  logic [STAT_W-1:0] stat_code;
  logic [CW-1:0]     i;
  logic [CW-1:0]     j;
  logic [CW-1:0]     k;

  logic [CW-1:0]     n;
  logic [MW-1:0]     total;
  logic [2*CW:0]     tot_prod;
  logic              accept;

  function automatic logic [AW-1:0] tri_addr(input logic [CW-1:0] r,
                                             input logic [CW-1:0] c);
    logic [2*CW:0] p;
    p = (2*CW+1)'(c) * ((2*CW+1)'(c) + 1'b1);
    return AW'((p >> 1) + (2*CW+1)'(r));
  endfunction

  always_comb begin
    if (cfg_size == '0) begin
      n = CW'(1);
    end else if (32'(cfg_size) > MAX_ORDER) begin
      n = CW'(MAX_ORDER);
    end else begin
      n = CW'(cfg_size);
    end
  end

  assign tot_prod = (2*CW+1)'(n) * ((2*CW+1)'(n) + 1'b1);
  assign total    = MW'(tot_prod >> 1);
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign emit_index = IDX_W'(i);

  always_comb begin
    cmd  = '0;
    f_ra = tri_addr(i, j);
    f_rb = tri_addr(i, i);
    f_wa = mcount;
    v_ra = IW'(i);
    v_wa = vcount;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_MATRIX) begin
            cmd.f_we = 1'b1;
          end else begin
            cmd.v_we = 1'b1;
          end
        end
      end
      S_BASE: begin
      end
      S_LOAD: begin
        cmd.acc_load    = 1'b1;
        cmd.acc_src_vec = (mode != M_FACT);
      end
      S_RD: begin
        f_ra = (mode == M_BWD) ? tri_addr(i, k) : tri_addr(k, i);
        f_rb = tri_addr(k, j);
        v_ra = IW'(k);
      end
      S_MUL: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_b_vec = (mode != M_FACT);
      end
      S_ACC: begin
        cmd.acc_sub = 1'b1;
      end
      S_SUM: begin
        cmd.sum_latch = 1'b1;
      end
      S_OP: begin
        if (mode == M_FACT && i == j) begin
          cmd.sqrt_start = stat.sum_pos;
        end else begin
          cmd.div_start = 1'b1;
        end
      end
      S_WAIT: begin
        if (stat.unit_done) begin
          if (mode == M_FACT) begin
            cmd.f_we        = 1'b1;
            cmd.f_wsel_unit = 1'b1;
            f_wa            = tri_addr(i, j);
          end else begin
            cmd.v_we        = 1'b1;
            cmd.v_wsel_unit = 1'b1;
            v_wa            = IW'(i);
          end
        end
      end
      S_E_RD: begin
      end
      S_E_OUT: begin
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_kind   = RES_SOLUTION;
          cmd.emit_status = ST_OK;
          cmd.emit_last   = (i + 1'b1 == n);
        end
      end
      S_STAT: begin
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_kind   = RES_STATUS;
          cmd.emit_status = stat_code;
          cmd.emit_last   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mode      <= M_FACT;
      cfg_size  <= SIZE_RESET;
      mcount    <= '0;
      vcount    <= '0;
      fgood     <= 1'b0;
      stat_code <= ST_OK;
      i         <= '0;
      j         <= '0;
      k         <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_kind == KIND_MATRIX) begin
              if (mcount == '0) begin
                fgood <= 1'b0;
              end
              vcount <= '0;
              if (MW'(mcount) + 1'b1 == total) begin
                mcount <= '0;
                mode   <= M_FACT;
                i      <= '0;
                j      <= '0;
                state  <= S_BASE;
              end else begin
                mcount <= mcount + 1'b1;
              end
            end else begin
              if (CW'(vcount) + 1'b1 == n) begin
                vcount <= '0;
                if (!fgood) begin
                  stat_code <= ST_NO_FACTOR;
                  state     <= S_STAT;
                end else begin
                  mode  <= M_FWD;
                  i     <= '0;
                  state <= S_BASE;
                end
              end else begin
                vcount <= vcount + 1'b1;
              end
            end
          end
        end
        S_BASE: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (mode == M_BWD) begin
            k     <= i + 1'b1;
            state <= (i + 1'b1 < n) ? S_RD : S_SUM;
          end else begin
            k     <= '0;
            state <= (i != '0) ? S_RD : S_SUM;
          end
        end
        S_RD: begin
          state <= S_MUL;
        end
        S_MUL: begin
          state <= S_ACC;
        end
        S_ACC: begin
          k <= k + 1'b1;
          if (mode == M_BWD) begin
            state <= (k + 1'b1 < n) ? S_RD : S_SUM;
          end else begin
            state <= (k + 1'b1 < i) ? S_RD : S_SUM;
          end
        end
        S_SUM: begin
          state <= S_OP;
        end
        S_OP: begin
          if (mode == M_FACT && i == j && !stat.sum_pos) begin
            stat_code <= ST_NOT_PD;
            fgood     <= 1'b0;
            state     <= S_STAT;
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (stat.unit_done) begin
            unique case (mode)
              M_FACT: begin
                if (j + 1'b1 < n) begin
                  j     <= j + 1'b1;
                  state <= S_BASE;
                end else if (i + 1'b1 < n) begin
                  i     <= i + 1'b1;
                  j     <= i + 1'b1;
                  state <= S_BASE;
                end else begin
                  fgood     <= 1'b1;
                  stat_code <= ST_OK;
                  state     <= S_STAT;
                end
              end
              M_FWD: begin
                if (i + 1'b1 < n) begin
                  i <= i + 1'b1;
                end else begin
                  mode <= M_BWD;
                end
                state <= S_BASE;
              end
              M_BWD: begin
                if (i == '0) begin
                  state <= S_E_RD;
                end else begin
                  i     <= i - 1'b1;
                  state <= S_BASE;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_E_RD: begin
          state <= S_E_OUT;
        end
        S_E_OUT: begin
          if (stat.out_free) begin
            if (i + 1'b1 == n) begin
              state <= S_IDLE;
            end else begin
              i     <= i + 1'b1;
              state <= S_E_RD;
            end
          end
        end
        S_STAT: begin
          if (stat.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // The user must write the order register only while the unit is idle; the block does not enforce it.
      if (cfg_we) begin
        cfg_size <= cfg_wdata;
        mcount   <= '0;
        vcount   <= '0;
        fgood    <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/packed_cholesky_solver_unit.sv -----
// Top level of the packed Cholesky factor-and-solve unit.
//
//   Channel   Dir  Handshake         Payload
//   cfg       in   cfg_we            cfg_wdata (matrix order)
//   load      in   valid/ready       kind, value
//   result    out  valid/ready       result_kind, status, index, solved_value, last
//
// Load elements are taken only while the controller is idle. The transfer of
// the last packed element starts the factorization, which works through
// the inner products of element (i,j) plus the wait on the iterative unit,
// which makes a square root or a division one bit per cycle. A solve runs
// the forward and then the back pass row by row, then emits the solution
// elements. The multiply-accumulate loop and the shared div/sqrt unit do
// this work.
// Reset clears only control state; the stores hold nothing valid until
// loaded, and the counters keep every read behind a write, so there is no
// clearing pass. A stalled result holds in the output register; a single
// waiting result does not block the transfer of the next load element.
`default_nettype none

module packed_cholesky_solver_unit import pcs_pkg::*; #(
  parameter int MAX_ORDER = MAX_ORDER_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata,
  pcs_in_if.sink            load,
  pcs_out_if.source         result
);

  localparam int AW = $clog2(MAX_ORDER * (MAX_ORDER + 1) / 2);
  localparam int IW = $clog2(MAX_ORDER);

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [AW-1:0]    f_ra;
  logic [AW-1:0]    f_rb;
  logic [AW-1:0]    f_wa;
  logic [IW-1:0]    v_ra;
  logic [IW-1:0]    v_wa;
  logic [IDX_W-1:0] emit_index;

  // The controller owns the order register, the load counters and the
  // sequencing of the factor and solve passes.
  pcs_ctrl #(.MAX_ORDER(MAX_ORDER)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (load.valid),
    .in_kind    (load.kind),
    .in_ready   (load.ready),
    .stat       (stat),
    .cmd        (cmd),
    .f_ra       (f_ra),
    .f_rb       (f_rb),
    .f_wa       (f_wa),
    .v_ra       (v_ra),
    .v_wa       (v_wa),
    .emit_index (emit_index)
  );

  // The datapath holds the stores, the accumulator, the div/sqrt unit and
  // the result register that drives the output channel.
  pcs_datapath #(.MAX_ORDER(MAX_ORDER), .FRAC_BITS(FRAC_BITS)) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .f_ra            (f_ra),
    .f_rb            (f_rb),
    .f_wa            (f_wa),
    .v_ra            (v_ra),
    .v_wa            (v_wa),
    .emit_index      (emit_index),
    .in_value        (load.value),
    .out_ready       (result.ready),
    .out_valid       (result.valid),
    .out_result_kind (result.result_kind),
    .out_status      (result.status),
    .out_index       (result.index),
    .out_value       (result.solved_value),
    .out_last        (result.last)
  );

endmodule

`default_nettype wire

// ----- tb/packed_cholesky_solver_unit_tb.sv -----
// Self-checking testbench for the packed Cholesky factor-and-solve unit.
`default_nettype none

module packed_cholesky_solver_unit_tb;
  import pcs_pkg::*;

  localparam int ORDER_MAX = MAX_ORDER_DEF;
  localparam int FRAC = FRAC_BITS_DEF;
  localparam int TRI_MAX = ORDER_MAX * (ORDER_MAX + 1) / 2;
  localparam longint CYCLE_LIMIT = 3000000;

  // One element headed into the unit: matrix element or right-hand side element.
  typedef struct {
    logic                     kind;
    logic signed [DATA_W-1:0] value;
  } load_item_t;

  // One result coming back from the unit.
  typedef struct {
    logic                     result_kind;
    logic [STAT_W-1:0]        status;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] solved_value;
    logic                     last;
  } solve_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [SIZE_W-1:0] cfg_wdata;

  pcs_in_if  load_ch ();
  pcs_out_if result_ch ();

  packed_cholesky_solver_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .load      (load_ch.sink),
    .result    (result_ch.source)
  );

  // The predictor keeps its own copy of everything the unit remembers.
  logic [SIZE_W-1:0]        order_reg;
  logic signed [DATA_W-1:0] tri_store [TRI_MAX];
  logic signed [DATA_W-1:0] rhs_store [ORDER_MAX];
  int unsigned              mat_count;
  int unsigned              rhs_count;
  bit                       have_factor;

  load_item_t    pending_loads[$];
  solve_result_t expected_results[$];

  int  error_count;
  int  result_count;
  int  status_count;
  int  solution_count;
  longint cycle_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Cycle counter with a generous limit so a hung unit cannot stall the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Fixed-point arithmetic of the predictor, all in 64-bit signed terms.
  // ---------------------------------------------------------------------
  function automatic logic signed [DATA_W-1:0] clamp32(input logic signed [ACC_W-1:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[DATA_W-1:0];
  endfunction

  // Product rounded half up to FRAC fraction bits; an arithmetic shift floors.
  function automatic logic signed [ACC_W-1:0] fx_mul(input logic signed [DATA_W-1:0] a,
                                                     input logic signed [DATA_W-1:0] b);
    logic signed [ACC_W-1:0] p;
    p = ACC_W'(a) * ACC_W'(b) + (64'sd1 <<< (FRAC - 1));
    return p >>> FRAC;
  endfunction

  // Quotient truncated toward zero; a zero divisor saturates by the sign of the sum.
  function automatic logic signed [DATA_W-1:0] fx_div(input logic signed [DATA_W-1:0] num,
                                                      input logic signed [DATA_W-1:0] den);
    logic signed [ACC_W-1:0] q;
    if (den == 0) return (num >= 0) ? 32'sh7fffffff : 32'sh80000000;
    q = (ACC_W'(num) <<< FRAC) / ACC_W'(den);
    return clamp32(q);
  endfunction

  function automatic logic [ACC_W-1:0] floor_sqrt(input logic [ACC_W-1:0] v);
    logic [ACC_W-1:0] root;
    logic [ACC_W-1:0] bitv;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic int unsigned packed_pos(input int unsigned row, input int unsigned col);
    return col * (col + 1) / 2 + row;
  endfunction

  function automatic int unsigned active_order();
    if (order_reg == 0) return 1;
    if (order_reg > ORDER_MAX) return ORDER_MAX;
    return order_reg;
  endfunction

  // In-place factorization as R^T * R; returns the status code for the run.
  function automatic logic [STAT_W-1:0] factor_in_place(input int unsigned n);
    logic signed [ACC_W-1:0]  acc;
    logic signed [DATA_W-1:0] sum;
    for (int unsigned i = 0; i < n; i++) begin
      for (int unsigned j = i; j < n; j++) begin
        acc = ACC_W'(tri_store[packed_pos(i, j)]);
        for (int unsigned k = 0; k < i; k++)
          acc -= fx_mul(tri_store[packed_pos(k, i)], tri_store[packed_pos(k, j)]);
        sum = clamp32(acc);
        if (i == j) begin
          if (sum <= 0) return ST_NOT_PD;
          tri_store[packed_pos(i, j)] =
            DATA_W'(floor_sqrt(ACC_W'(unsigned'(sum)) << FRAC));
        end else begin
          tri_store[packed_pos(i, j)] = fx_div(sum, tri_store[packed_pos(i, i)]);
        end
      end
    end
    return ST_OK;
  endfunction

  function automatic solve_result_t status_result(input logic [STAT_W-1:0] st);
    solve_result_t r;
    r.result_kind = RES_STATUS;
    r.status = st;
    r.index = '0;
    r.solved_value = '0;
    r.last = 1'b1;
    return r;
  endfunction

  // Forward then back substitution; pushes the solution in index order.
  task automatic predict_solution(input int unsigned n);
    logic signed [DATA_W-1:0] x [ORDER_MAX];
    logic signed [ACC_W-1:0]  acc;
    solve_result_t r;
    for (int unsigned i = 0; i < n; i++) begin
      acc = ACC_W'(rhs_store[i]);
      for (int unsigned j = 0; j < i; j++) acc -= fx_mul(tri_store[packed_pos(j, i)], x[j]);
      x[i] = fx_div(clamp32(acc), tri_store[packed_pos(i, i)]);
    end
    for (int i = int'(n) - 1; i >= 0; i--) begin
      acc = ACC_W'(x[i]);
      for (int unsigned j = i + 1; j < n; j++) acc -= fx_mul(tri_store[packed_pos(i, j)], x[j]);
      x[i] = fx_div(clamp32(acc), tri_store[packed_pos(i, i)]);
    end
    for (int unsigned i = 0; i < n; i++) begin
      r.result_kind = RES_SOLUTION;
      r.status = ST_OK;
      r.index = IDX_W'(i);
      r.solved_value = x[i];
      r.last = (i + 1 == n);
      expected_results.push_back(r);
    end
  endtask

  // Advances the predictor by one accepted transfer on the load channel.
  task automatic predict_load(input load_item_t it);
    int unsigned n;
    logic [STAT_W-1:0] st;
    n = active_order();
    if (it.kind == KIND_MATRIX) begin
      if (mat_count == 0) have_factor = 1'b0;
      rhs_count = 0;
      if (mat_count < TRI_MAX) tri_store[mat_count] = it.value;
      mat_count++;
      if (mat_count >= n * (n + 1) / 2) begin
        st = factor_in_place(n);
        mat_count = 0;
        have_factor = (st == ST_OK);
        expected_results.push_back(status_result(st));
      end
    end else begin
      if (rhs_count < ORDER_MAX) rhs_store[rhs_count] = it.value;
      rhs_count++;
      if (rhs_count >= n) begin
        rhs_count = 0;
        if (!have_factor) expected_results.push_back(status_result(ST_NO_FACTOR));
        else predict_solution(n);
      end
    end
  endtask

  function automatic int unsigned gap_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------
  // Driver: presents queued elements with random gaps between transfers.
  // ---------------------------------------------------------------------
  int unsigned drive_gap;
  bit          drive_quiet;

  always @(posedge clk) begin
    if (rst) begin
      load_ch.valid <= 1'b0;
      load_ch.kind <= KIND_MATRIX;
      load_ch.value <= '0;
      drive_gap <= 0;
    end else if (load_ch.valid && !load_ch.ready) begin
      // Hold the current element until the unit takes it.
    end else begin
      if (load_ch.valid) predict_load('{kind: load_ch.kind, value: load_ch.value});
      if (drive_gap != 0) begin
        load_ch.valid <= 1'b0;
        drive_gap <= drive_gap - 1;
      end else if (pending_loads.size() != 0) begin
        load_item_t it;
        it = pending_loads.pop_front();
        load_ch.valid <= 1'b1;
        load_ch.kind <= it.kind;
        load_ch.value <= it.value;
        drive_gap <= drive_quiet ? 0 : gap_len();
      end else begin
        load_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: random back-pressure, and each result transfer is checked.
  // ---------------------------------------------------------------------
  int unsigned stall_left;

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        solve_result_t want;
        result_count++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result kind=%0d status=%0d index=%0d value=%0d", $time,
                   result_ch.result_kind, result_ch.status, result_ch.index,
                   result_ch.solved_value);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (want.result_kind == RES_STATUS) status_count++;
          else solution_count++;
          if (result_ch.result_kind !== want.result_kind || result_ch.status !== want.status ||
              result_ch.index !== want.index || result_ch.solved_value !== want.solved_value ||
              result_ch.last !== want.last) begin
            $display("%0t: mismatch expected kind=%0d status=%0d index=%0d value=%0d last=%0d",
                     $time, want.result_kind, want.status, want.index, want.solved_value,
                     want.last);
            $display("%0t:          actual   kind=%0d status=%0d index=%0d value=%0d last=%0d",
                     $time, result_ch.result_kind, result_ch.status, result_ch.index,
                     result_ch.solved_value, result_ch.last);
            error_count++;
          end
        end
      end
      if (stall_left != 0) begin
        result_ch.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        result_ch.ready <= 1'b1;
        if (!drive_quiet && $urandom_range(0, 3) == 0) stall_left <= gap_len();
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus construction.
  // ---------------------------------------------------------------------
  function automatic logic signed [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      default: return $signed($urandom_range(0, 8 << FRAC)) - (4 <<< FRAC);
    endcase
  endfunction

  task automatic queue_item(input logic kind, input logic signed [DATA_W-1:0] value);
    load_item_t it;
    it.kind = kind;
    it.value = value;
    pending_loads.push_back(it);
  endtask

  // A diagonally dominant matrix is positive definite, so the solve is reached.
  task automatic queue_good_matrix(input int unsigned n);
    for (int unsigned col = 0; col < n; col++)
      for (int unsigned row = 0; row <= col; row++)
        if (row == col) queue_item(KIND_MATRIX, $signed($urandom_range(n + 1, 4 * n + 4)) <<< FRAC);
        else queue_item(KIND_MATRIX, $signed($urandom_range(0, 2 << FRAC)) - (1 <<< FRAC));
  endtask

  task automatic queue_rhs(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) queue_item(KIND_RHS, rand_value());
  endtask

  task automatic wait_drained();
    while (pending_loads.size() != 0 || load_ch.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (2000) @(posedge clk);
  endtask

  // Only written while the unit is idle; predictor copy is cleared alongside.
  task automatic set_order(input logic [SIZE_W-1:0] sz);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= sz;
    order_reg = sz;
    mat_count = 0;
    rhs_count = 0;
    have_factor = 1'b0;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  int unsigned phase_order;

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    load_ch.valid = 1'b0;
    load_ch.kind = KIND_MATRIX;
    load_ch.value = '0;
    result_ch.ready = 1'b0;
    order_reg = SIZE_RESET;
    mat_count = 0;
    rhs_count = 0;
    have_factor = 1'b0;
    error_count = 0;
    result_count = 0;
    status_count = 0;
    solution_count = 0;
    cycle_count = 0;
    drive_quiet = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part at order 2: extremes, a solve with no factor, and bad pivots.
    set_order(5'd2);
    queue_rhs(2);                         // right-hand side before any factor
    queue_item(KIND_MATRIX, 32'sh7fffffff);
    queue_item(KIND_MATRIX, 32'sh80000000);
    queue_item(KIND_MATRIX, 32'sh7fffffff);
    queue_item(KIND_RHS, 32'sh7fffffff);
    queue_item(KIND_RHS, 32'sh80000000);
    queue_item(KIND_MATRIX, 32'sh0);      // zero pivot
    queue_item(KIND_MATRIX, 32'sh1);
    queue_item(KIND_MATRIX, 32'sh1);
    queue_item(KIND_RHS, 32'sh1);
    queue_item(KIND_RHS, 32'shffffffff);  // no factor after the bad pivot
    queue_item(KIND_MATRIX, -(32'sd1 <<< FRAC));  // negative pivot
    queue_item(KIND_MATRIX, 32'sh0);
    queue_item(KIND_MATRIX, 32'sh0);
    queue_good_matrix(2);
    queue_rhs(2);
    wait_drained();

    // Order 0 behaves as 1; an order above the maximum behaves as the maximum.
    set_order(5'd0);
    queue_item(KIND_MATRIX, 32'sh00010000);
    queue_item(KIND_RHS, 32'sh55555555);
    wait_drained();
    set_order(5'd31);
    queue_good_matrix(ORDER_MAX);
    queue_rhs(ORDER_MAX);
    wait_drained();

    // Random phases: mostly small orders, one at the largest.
    for (int phase = 0; phase < 6; phase++) begin
      phase_order = (phase % 5 == 4) ? ORDER_MAX : $urandom_range(1, 5);
      drive_quiet = (phase % 4 == 3);
      set_order(SIZE_W'(phase_order));
      for (int rep = 0; rep < (phase_order > 8 ? 1 : 2); rep++) begin
        if ($urandom_range(0, 9) < 7) queue_good_matrix(phase_order);
        else for (int unsigned e = 0; e < phase_order * (phase_order + 1) / 2; e++)
          queue_item(KIND_MATRIX, rand_value());
        queue_rhs(phase_order);
        if ($urandom_range(0, 4) == 0) queue_item(1'($urandom_range(0, 1)), rand_value());
      end
      wait_drained();
    end
    drive_quiet = 1'b0;

    $display("covered %0d results: %0d status and %0d solution elements, orders 0 to 31",
             result_count, status_count, solution_count);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
